// ===== rtl/skp_pkg.sv =====
// Package for the skyline rectangle packer: request and response transaction types,
// status codes, configuration register indexes and controller states.
// No dependencies.
package skp_pkg;

   localparam int REQ_DIM_W = 13;
   localparam int POS_W     = 12;

   typedef enum logic [1:0] {
      STATUS_PLACED   = 2'd0,
      STATUS_NO_ROOM  = 2'd1,
      STATUS_OVERSIZE = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   localparam logic CSR_ATLAS_WIDTH  = 1'b0;
   localparam logic CSR_ATLAS_HEIGHT = 1'b1;

   typedef struct packed {
      logic [REQ_DIM_W-1:0] rect_width;
      logic [REQ_DIM_W-1:0] rect_height;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      status_type       status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_OUT_RD,
      ST_OUT_CHK,
      ST_IN_RD,
      ST_IN_CHK,
      ST_CAND,
      ST_DECIDE,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_PLAN,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_WR_BEST,
      ST_WR_NEXT
   } state_type;

endpackage

// ===== rtl/skp_seg_mem.sv =====
// Segment table memory: one synchronous RAM holding x start and height per entry.
// One write and one registered read per cycle. Depends on nothing.
module skp_seg_mem #(
   parameter int DEPTH = 256,
   parameter int DW    = 13
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_start,
   output logic [DW-1:0]            rd_height,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_start,
   input  logic [DW-1:0]            wr_height
);

   logic [2*DW-1:0] mem [DEPTH];
   logic [2*DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_start, wr_height};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_start  = rd_data_ff[2*DW-1:DW];
   assign rd_height = rd_data_ff[DW-1:0];

endmodule

// ===== rtl/skp_ctrl.sv =====
// Sequencer of the skyline packer: scans the segment table, picks the bottom-left
// position and rewrites the table in place. Depends on skp_pkg and skp_seg_mem ports.
module skp_ctrl
   import skp_pkg::*;
#(
   parameter int MAX_SEGMENTS = 256,
   parameter int MAX_DIM      = 4096,
   localparam int DW = ($clog2(MAX_DIM + 1) > REQ_DIM_W) ? $clog2(MAX_DIM + 1) : REQ_DIM_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  req_type                         req_data,
   output logic                            rsp_strobe,
   output rsp_type                         rsp_data,
   input  logic [REQ_DIM_W-1:0]            cfg_width,
   input  logic [REQ_DIM_W-1:0]            cfg_height,
   output logic [$clog2(MAX_SEGMENTS)-1:0] rd_addr,
   input  logic [DW-1:0]                   rd_start,
   input  logic [DW-1:0]                   rd_height,
   output logic                            wr_en,
   output logic [$clog2(MAX_SEGMENTS)-1:0] wr_addr,
   output logic [DW-1:0]                   wr_start,
   output logic [DW-1:0]                   wr_height
);

   localparam int SW = DW + 1;
   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int XW = CW + 1;
   localparam logic [DW-1:0] DIM_MAX = DW'(MAX_DIM);
   localparam logic [CW-1:0] SEG_MAX = CW'(MAX_SEGMENTS);

   state_type state_ff, state_in;
   logic [DW-1:0] w_ff, w_in, h_ff, h_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, best_ff, best_in;
   logic [CW-1:0] rem_ff, rem_in, count_ff, count_in;
   logic [DW-1:0] x_ff, x_in, bx_ff, bx_in, top_ff, top_in, besty_ff, besty_in;
   logic [DW-1:0] hi_ff, hi_in, jh_ff, jh_in;
   logic [SW-1:0] right_ff, right_in, end_ff, end_in;
   logic          found_ff, found_in;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic [DW-1:0] aw, ah, req_w, req_h;
   logic [SW-1:0] out_sum, top_sum;
   logic [XW-1:0] cnt_x, i_x, j_x;

   assign aw = (DW'(cfg_width) > DIM_MAX) ? DIM_MAX : DW'(cfg_width);
   assign ah = (DW'(cfg_height) > DIM_MAX) ? DIM_MAX : DW'(cfg_height);
   assign req_w   = DW'(req_data.rect_width);
   assign req_h   = DW'(req_data.rect_height);
   assign out_sum = SW'(rd_start) + SW'(w_ff);
   assign top_sum = SW'(besty_ff) + SW'(h_ff);
   assign cnt_x   = XW'(count_ff);
   assign i_x     = XW'(i_ff);
   assign j_x     = XW'(j_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         count_ff  <= CW'(1);
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      w_ff     <= w_in;
      h_ff     <= h_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      best_ff  <= best_in;
      rem_ff   <= rem_in;
      x_ff     <= x_in;
      bx_ff    <= bx_in;
      top_ff   <= top_in;
      besty_ff <= besty_in;
      hi_ff    <= hi_in;
      jh_ff    <= jh_in;
      right_ff <= right_in;
      end_ff   <= end_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in  = state_ff;
      w_in      = w_ff;
      h_in      = h_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      best_in   = best_ff;
      rem_in    = rem_ff;
      count_in  = count_ff;
      x_in      = x_ff;
      bx_in     = bx_ff;
      top_in    = top_ff;
      besty_in  = besty_ff;
      hi_in     = hi_ff;
      jh_in     = jh_ff;
      right_in  = right_ff;
      end_in    = end_ff;
      found_in  = found_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_start  = '0;
      wr_height = '0;

      unique case (state_ff)
         ST_INIT: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (req_w == '0 || req_h == '0 || req_w > aw || req_h > ah) begin
                  strobe_in = 1'b1;
                  rsp_in    = '{pos_x: '0, pos_y: '0, status: STATUS_OVERSIZE};
               end else begin
                  w_in     = req_w;
                  h_in     = req_h;
                  i_in     = '0;
                  besty_in = ah;
                  found_in = 1'b0;
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_OUT_RD: begin
            rd_addr  = i_ff[AW-1:0];
            state_in = ST_OUT_CHK;
         end
         ST_OUT_CHK: begin
            if (out_sum > SW'(aw)) begin
               state_in = ST_DECIDE;
            end else begin
               x_in     = rd_start;
               right_in = out_sum;
               top_in   = rd_height;
               hi_in    = rd_height;
               j_in     = i_ff + CW'(1);
               state_in = (i_x + XW'(1) < cnt_x) ? ST_IN_RD : ST_CAND;
            end
         end
         ST_IN_RD: begin
            rd_addr  = j_ff[AW-1:0];
            state_in = ST_IN_CHK;
         end
         ST_IN_CHK: begin
            if (SW'(rd_start) < right_ff) begin
               if (rd_height > top_ff) begin
                  top_in = rd_height;
               end
               j_in     = j_ff + CW'(1);
               state_in = (j_x + XW'(1) < cnt_x) ? ST_IN_RD : ST_CAND;
            end else begin
               state_in = ST_CAND;
            end
         end
         ST_CAND: begin
            if (top_ff < besty_ff) begin
               besty_in = top_ff;
               best_in  = i_ff;
               bx_in    = x_ff;
               jh_in    = hi_ff;
               found_in = 1'b1;
            end
            i_in     = i_ff + CW'(1);
            state_in = (i_x + XW'(1) < cnt_x) ? ST_OUT_RD : ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!found_ff || top_sum > SW'(ah)) begin
               strobe_in = 1'b1;
               rsp_in    = '{pos_x: '0, pos_y: '0, status: STATUS_NO_ROOM};
               state_in  = ST_IDLE;
            end else begin
               end_in   = SW'(bx_ff) + SW'(w_ff);
               j_in     = best_ff;
               state_in = (XW'(best_ff) + XW'(1) < cnt_x) ? ST_WALK_RD : ST_PLAN;
            end
         end
         ST_WALK_RD: begin
            rd_addr  = AW'(j_ff + CW'(1));
            state_in = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            if (SW'(rd_start) < end_ff) begin
               j_in     = j_ff + CW'(1);
               jh_in    = rd_height;
               state_in = (j_x + XW'(2) < cnt_x) ? ST_WALK_RD : ST_PLAN;
            end else begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            rem_in = j_ff - best_ff;
            if (j_ff == best_ff && count_ff == SEG_MAX) begin
               strobe_in = 1'b1;
               rsp_in    = '{pos_x: '0, pos_y: '0, status: STATUS_FULL};
               state_in  = ST_IDLE;
            end else if (j_ff == best_ff) begin
               k_in     = count_ff - CW'(1);
               state_in = ST_MOVE_RD;
            end else if (j_ff == best_ff + CW'(1)) begin
               state_in = ST_WR_BEST;
            end else begin
               k_in     = j_ff;
               state_in = ST_MOVE_RD;
            end
         end
         ST_MOVE_RD: begin
            rd_addr  = k_ff[AW-1:0];
            state_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            wr_en     = 1'b1;
            wr_addr   = AW'(k_ff + CW'(1) - rem_ff);
            wr_start  = rd_start;
            wr_height = rd_height;
            if (rem_ff == '0) begin
               if (k_ff == j_ff) begin
                  state_in = ST_WR_BEST;
               end else begin
                  k_in     = k_ff - CW'(1);
                  state_in = ST_MOVE_RD;
               end
            end else begin
               if (XW'(k_ff) + XW'(1) == cnt_x) begin
                  state_in = ST_WR_BEST;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = ST_MOVE_RD;
               end
            end
         end
         ST_WR_BEST: begin
            wr_en     = 1'b1;
            wr_addr   = best_ff[AW-1:0];
            wr_start  = bx_ff;
            wr_height = top_sum[DW-1:0];
            state_in  = ST_WR_NEXT;
         end
         ST_WR_NEXT: begin
            wr_en     = 1'b1;
            wr_addr   = AW'(best_ff + CW'(1));
            wr_start  = end_ff[DW-1:0];
            wr_height = jh_ff;
            count_in  = count_ff - rem_ff + CW'(1);
            strobe_in = 1'b1;
            rsp_in    = '{pos_x: bx_ff[POS_W-1:0], pos_y: besty_ff[POS_W-1:0],
                          status: STATUS_PLACED};
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // The table always holds at least one segment and never more than its depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(1) && count_ff <= SEG_MAX)
      else $error("segment count out of range");

   // Writes never land beyond the entry just past the current table end.
   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CW'(wr_addr) <= count_ff)
      else $error("segment write beyond table end");

   // A rejected request reports a zero position.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != STATUS_PLACED |->
         rsp_data.pos_x == '0 && rsp_data.pos_y == '0)
      else $error("rejected request with nonzero position");

   // An accepted request either finishes at once with a response or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("accepted transaction dropped");

endmodule

// ===== rtl/skyline_rect_packer.sv =====
// Top level of the skyline bottom-left rectangle packer: configuration registers,
// sequencer and segment table memory. Depends on skp_pkg, skp_ctrl and skp_seg_mem.
//
// The block places rectangles into an atlas by the skyline bottom-left rule. A request
// transaction is taken at a rising edge with start high and busy low; exactly one
// response transaction follows, shown on rsp_data for one cycle with rsp_strobe high.
// The receiver cannot stall, so the response must be captured in that cycle. A request
// that is zero-sized or larger than the atlas is answered in the next cycle. Otherwise
// the sequencer walks the segment table stored in one single-port-read memory, with a
// read state and a check state per entry read: for each candidate start it reads that
// entry and every further entry the span covers, then walks the covered entries once
// more, then shifts the tail of the table one entry at a time (a read and a write state
// per moved entry) and writes two entries. After reset the block stays busy in its
// init state while it writes the initial floor segment. Atlas width and height are
// written through csr_we, csr_index and csr_wdata; the user must write them only while
// the block is idle, as the block itself does not enforce this. Values above MAX_DIM
// act as MAX_DIM.
module skyline_rect_packer
   import skp_pkg::*;
#(
   parameter int MAX_SEGMENTS = 256,
   parameter int MAX_DIM      = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [REQ_DIM_W-1:0] csr_wdata
);

   localparam int DW = ($clog2(MAX_DIM + 1) > REQ_DIM_W) ? $clog2(MAX_DIM + 1) : REQ_DIM_W;
   localparam int AW = $clog2(MAX_SEGMENTS);

   logic [REQ_DIM_W-1:0] atlas_width_ff, atlas_height_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [DW-1:0] rd_start, rd_height, wr_start, wr_height;
   logic          wr_en;

   // Both registers come out of reset at the full 4096 pixel atlas.
   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_width_ff  <= REQ_DIM_W'(4096);
         atlas_height_ff <= REQ_DIM_W'(4096);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ATLAS_WIDTH:  atlas_width_ff  <= csr_wdata;
            CSR_ATLAS_HEIGHT: atlas_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   skp_ctrl #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .MAX_DIM      (MAX_DIM)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .cfg_width  (atlas_width_ff),
      .cfg_height (atlas_height_ff),
      .rd_addr    (rd_addr),
      .rd_start   (rd_start),
      .rd_height  (rd_height),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_start   (wr_start),
      .wr_height  (wr_height)
   );

   skp_seg_mem #(
      .DEPTH (MAX_SEGMENTS),
      .DW    (DW)
   ) u_seg_mem (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .rd_start  (rd_start),
      .rd_height (rd_height),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_start  (wr_start),
      .wr_height (wr_height)
   );

endmodule

// ===== bench/tb_skyline_rect_packer.sv =====
// Self-checking testbench for the skyline rectangle packer: drives request and
// register transactions and checks every response against a built-in predictor.
// Depends on skp_pkg and skyline_rect_packer.
`timescale 1ns / 100ps

module tb_skyline_rect_packer;
   import skp_pkg::*;

   localparam int SEG_DEPTH = 256;
   localparam int DIM_LIMIT = 4096;

   // Placement predictor and queue of expected responses. It keeps its own
   // copy of the skyline table and of the atlas size registers.
   class placement_board;
      int unsigned seg_x[SEG_DEPTH];
      int unsigned seg_y[SEG_DEPTH];
      int unsigned seg_count;
      int unsigned atlas_w;
      int unsigned atlas_h;
      rsp_type     expected_q[$];
      int          errors;
      int          status_seen[4];

      function new();
         seg_x[0]  = 0;
         seg_y[0]  = 0;
         seg_count = 1;
         atlas_w   = 4096;
         atlas_h   = 4096;
         errors    = 0;
         foreach (status_seen[k]) status_seen[k] = 0;
      endfunction

      function void write_reg(logic index, logic [REQ_DIM_W-1:0] value);
         if (index == CSR_ATLAS_WIDTH) atlas_w = 32'(value);
         else atlas_h = 32'(value);
      endfunction

      // Works out the placement for one accepted request and updates the table.
      function void note_request(req_type req);
         int unsigned w, h, aw, ah, best, best_y, top, x, right, j, new_count, k;
         int unsigned tmp_x[SEG_DEPTH];
         int unsigned tmp_y[SEG_DEPTH];
         bit          found;
         rsp_type     r;
         w = 32'(req.rect_width);
         h = 32'(req.rect_height);
         aw = (atlas_w > DIM_LIMIT) ? DIM_LIMIT : atlas_w;
         ah = (atlas_h > DIM_LIMIT) ? DIM_LIMIT : atlas_h;
         r.pos_x = '0;
         r.pos_y = '0;
         found = 0;
         best = 0;
         best_y = ah;
         if (w == 0 || h == 0 || w > aw || h > ah) begin
            r.status = STATUS_OVERSIZE;
         end else begin
            for (int i = 0; i < seg_count; i++) begin
               x = seg_x[i];
               if (x + w > aw) break;
               top = 0;
               for (int m = i; m < seg_count && seg_x[m] < x + w; m++)
                  if (seg_y[m] > top) top = seg_y[m];
               if (top < best_y) begin
                  best_y = top;
                  best = i;
                  found = 1;
               end
            end
            if (!found || best_y + h > ah) begin
               r.status = STATUS_NO_ROOM;
            end else begin
               right = seg_x[best] + w;
               j = best;
               while (j + 1 < seg_count && seg_x[j + 1] < right) j++;
               new_count = seg_count - (j - best) + 1;
               if (new_count > SEG_DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  tmp_x = seg_x;
                  tmp_y = seg_y;
                  // The tail from the last covered entry moves up behind the new segment.
                  for (k = j; k < seg_count; k++) begin
                     seg_x[best + 1 + k - j] = tmp_x[k];
                     seg_y[best + 1 + k - j] = tmp_y[k];
                  end
                  r.pos_x = POS_W'(tmp_x[best]);
                  r.pos_y = POS_W'(best_y);
                  seg_y[best] = best_y + h;
                  seg_x[best + 1] = right;
                  seg_count = new_count;
                  r.status = STATUS_PLACED;
               end
            end
         end
         expected_q.push_back(r);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: response with none expected: x=%0d y=%0d status=%0d",
                     $time, got.pos_x, got.pos_y, got.status);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         status_seen[want.status]++;
         if (got.pos_x !== want.pos_x) begin
            $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, got.pos_x);
            errors++;
         end
         if (got.pos_y !== want.pos_y) begin
            $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, got.pos_y);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic                 csr_index;
   logic [REQ_DIM_W-1:0] csr_wdata;

   placement_board board;
   int             gap_pct;
   int             sent;

   skyline_rect_packer uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock period.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Every response is checked at the edge that ends its strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_response(rsp_data);
   end

   // Presents one request transaction and waits for the edge that takes it.
   // Start stays high afterwards, so back-to-back requests never glitch it low;
   // a random gap lowers it on the next falling edge instead.
   task automatic send_rect(int unsigned w, int unsigned h);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(6)) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_data.rect_width  <= w[REQ_DIM_W-1:0];
      req_data.rect_height <= h[REQ_DIM_W-1:0];
      do @(posedge clock); while (busy);
      board.note_request(req_data);
      sent++;
   endtask

   // Lowers start and waits until every expected response has come back,
   // then waits on until busy is low so the block is surely idle.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Register writes happen only after a drain.
   task automatic write_csr(logic index, int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[REQ_DIM_W-1:0];
      board.write_reg(index, value[REQ_DIM_W-1:0]);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly sizes well inside the atlas so the skyline builds up; some
   // requests use the full 13-bit range, including zero and oversized values.
   function automatic int unsigned pick_dim(int unsigned limit);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return $urandom_range(8191);
      if (roll < 14) return limit;
      if (roll < 60) return $urandom_range(1, (limit > 8) ? limit / 8 : 1);
      return $urandom_range(1, (limit > 2) ? limit / 2 : 1);
   endfunction

   task automatic random_phase(int count, int pct, int unsigned w_lim, int unsigned h_lim);
      gap_pct = pct;
      repeat (count) send_rect(pick_dim(w_lim), pick_dim(h_lim));
   endtask

   initial begin
      board     = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_ATLAS_WIDTH;
      csr_wdata = '0;
      gap_pct   = 0;
      sent      = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      drain();

      // Directed part at the reset atlas size: zero sizes, the largest legal
      // sizes, oversize values, a full-width strip and stacking up to the top.
      send_rect(0, 10);
      send_rect(10, 0);
      send_rect(4097, 1);
      send_rect(1, 8191);
      send_rect(8191, 8191);
      send_rect(4096, 1);
      send_rect(100, 50);
      send_rect(100, 30);
      send_rect(3896, 20);
      send_rect(50, 4000);
      send_rect(1, 4045);
      send_rect(4096, 4096);
      drain();

      // The smallest atlas: only a 1x1 request can fit at all.
      write_csr(CSR_ATLAS_WIDTH, 1);
      write_csr(CSR_ATLAS_HEIGHT, 1);
      send_rect(1, 1);
      send_rect(1, 1);
      send_rect(2, 1);
      drain();

      // Values above the dimension limit act as the limit. Then the width
      // is shrunk below existing segments, which the scan must stop at.
      write_csr(CSR_ATLAS_WIDTH, 8191);
      write_csr(CSR_ATLAS_HEIGHT, 6000);
      send_rect(4096, 2);
      send_rect(200, 5);
      drain();
      write_csr(CSR_ATLAS_WIDTH, 150);
      send_rect(40, 10);
      send_rect(150, 3);
      send_rect(151, 1);
      drain();

      // Random part in several idling phases and atlas settings.
      write_csr(CSR_ATLAS_WIDTH, 512);
      write_csr(CSR_ATLAS_HEIGHT, 512);
      random_phase(30, 0, 512, 512);
      random_phase(30, 46, 512, 512);
      // Hold off until the block has answered everything before going on.
      drain();
      write_csr(CSR_ATLAS_WIDTH, 4096);
      write_csr(CSR_ATLAS_HEIGHT, 4096);
      random_phase(30, 9, 4096, 4096);
      drain();
      write_csr(CSR_ATLAS_WIDTH, 64);
      write_csr(CSR_ATLAS_HEIGHT, 300);
      random_phase(30, 46, 64, 300);
      random_phase(30, 0, 64, 300);
      drain();

      // Unit squares at full width add one segment each until the table is full.
      write_csr(CSR_ATLAS_WIDTH, 4096);
      write_csr(CSR_ATLAS_HEIGHT, 4096);
      gap_pct = 0;
      for (int n = 0; n < 300 && board.status_seen[STATUS_FULL] == 0; n++) begin
         send_rect(1, 1);
         if (n % 50 == 49) drain();
      end
      send_rect(1, 1);
      drain();
      repeat (20) @(posedge clock);

      $display("Covered %0d requests: %0d placed, %0d no room, %0d oversize, %0d table full.",
               sent, board.status_seen[STATUS_PLACED], board.status_seen[STATUS_NO_ROOM],
               board.status_seen[STATUS_OVERSIZE], board.status_seen[STATUS_FULL]);
      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("tb_skyline_rect_packer passed");
      end else begin
         $display("tb_skyline_rect_packer failed");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #1_000_000_000;
      $display("tb_skyline_rect_packer failed");
      $finish;
   end

endmodule
